// ===== src/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types, constants and range tables for the autorange resistance core.
// ----------------------------------------------------------------------------
package acr_pkg;

  // Store geometry
  localparam int NUM_DEVICES  = 2;
  localparam int NUM_CHANNELS = 4;
  localparam int STORE_SIZE   = NUM_DEVICES * NUM_CHANNELS;
  localparam int IDX_W        = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  // Field widths
  localparam int DEV_W       = 2;
  localparam int WORD_W      = 32;
  localparam int CODE_W      = 24;
  localparam int CH_W        = 4;
  localparam int LVL_W       = 3;
  localparam int COEFF_W     = 32;
  localparam int PROD_W      = CODE_W + COEFF_W;
  localparam int RES_W       = 40;
  localparam int MASK_W      = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // Code thresholds
  localparam logic [CODE_W-1:0] CODE_LOW       = 24'h346DC6;
  localparam logic [CODE_W-1:0] CODE_HIGH      = 24'hD1B717;
  localparam logic [CODE_W-1:0] CODE_L1_RETURN = 24'h01F751;
  localparam logic [CODE_W-1:0] CODE_L1_OVER   = 24'hF33333;

  localparam logic [LVL_W-1:0]  LVL_ZERO       = 3'd0;
  localparam logic [LVL_W-1:0]  LVL_ONE        = 3'd1;
  localparam logic [LVL_W-1:0]  LVL_RESET      = 3'd2;
  localparam logic [MASK_W-1:0] MASK_RESET     = 7'd64;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_BAD_DEVICE  = 3'd1,
    ERR_STATUS      = 3'd2,
    ERR_NOT_READY   = 3'd3,
    ERR_BAD_CHANNEL = 3'd4,
    ERR_BELOW_RANGE = 3'd5,
    ERR_BAD_CURRENT = 3'd6,
    ERR_ABOVE_RANGE = 3'd7
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_ONE   = 3'd0,
    REG_COEFF_TWO   = 3'd1,
    REG_COEFF_THREE = 3'd2,
    REG_COEFF_FOUR  = 3'd3,
    REG_COEFF_FIVE  = 3'd4,
    REG_COEFF_SIX   = 3'd5,
    REG_COEFF_SEVEN = 3'd6,
    REG_ERROR_MASK  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:1][COEFF_W-1:0] coeff;
    logic [MASK_W-1:0]       err_mask;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] status_data;
    logic [DEV_W-1:0]  device;
  } item_t;

  typedef struct packed {
    logic              level_changed;
    logic [LVL_W-1:0]  level_after;
    logic [LVL_W-1:0]  level_before;
    logic [RES_W-1:0]  resistance;
    logic [CH_W-1:0]   channel;
    err_e              error_code;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] level;
  } lvl_wr_t;

  // Next level on a high code (more current is too much)
  function automatic logic [LVL_W-1:0] step_down(input logic [LVL_W-1:0] lvl);
    logic [LVL_W-1:0] nl;
    case (lvl)
      3'd2:    nl = 3'd1;
      3'd3:    nl = 3'd2;
      3'd4:    nl = 3'd3;
      3'd5:    nl = 3'd4;
      3'd6:    nl = 3'd5;
      3'd7:    nl = 3'd5;
      default: nl = 3'd0;
    endcase
    return nl;
  endfunction

  // Next level on a low code; level seven falls off to below range
  function automatic logic [LVL_W-1:0] step_up(input logic [LVL_W-1:0] lvl);
    logic [LVL_W-1:0] nl;
    case (lvl)
      3'd2:    nl = 3'd3;
      3'd3:    nl = 3'd4;
      3'd4:    nl = 3'd5;
      3'd5:    nl = 3'd7;
      3'd6:    nl = 3'd7;
      default: nl = 3'd0;
    endcase
    return nl;
  endfunction

endpackage

// ===== src/adc_autorange_resistance_core.sv =====
// ----------------------------------------------------------------------------
// adc_autorange_resistance_core
// Autoranging resistance reader: converter words in, ohms and level out.
// ----------------------------------------------------------------------------
//  Channel    Dir  Beat contents (low bit first)
//  s_axis     in   device[1:0], status_data[33:2]
//  m_axis     out  error_code, channel, resistance, level_before, level_after,
//                  level_changed
//  cfg        in   write enable, register index, 32-bit write data
//
//  One beat per cycle sustained while results are taken; a beat passes the
//  input register, then the result register. Throughput is set by the 24x32
//  multiply and level store read-modify-write, in the stage between them.
//  Reset sets every stored level to two (flops, no clearing pass), the
//  coefficients to zero and the status error mask to 64.
//  A stalled result holds the result register; the input register still
//  takes a beat while it is empty.
// ----------------------------------------------------------------------------
module adc_autorange_resistance_core import acr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // fields: device[1:0], status_data[33:2], zero pad[39:34]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // fields: error_code[2:0], channel[6:3], resistance[46:7],
  // level_before[49:47], level_after[52:50], level_changed[53], zero pad[55:54]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  cfg_t             cfg;
  item_t            item_q;
  logic             in_vld_q;
  result_t          res_q;
  logic             out_vld_q;
  logic             adv;
  logic [IDX_W-1:0] rd_idx;
  logic [LVL_W-1:0] rd_level;
  result_t          calc_res;
  lvl_wr_t          calc_wr;
  lvl_wr_t          st_wr;

  acr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: stage moves when the result register is free or drained
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.device      <= s_axis_tdata[DEV_W-1:0];
      item_q.status_data <= s_axis_tdata[DEV_W+WORD_W-1:DEV_W];
    end
  end

  acr_range_calc u_calc (
    .item_i     (item_q),
    .cfg_i      (cfg),
    .rd_idx_o   (rd_idx),
    .rd_level_i (rd_level),
    .result_o   (calc_res),
    .wr_o       (calc_wr)
  );

  // Level write only when the item leaves the stage
  always_comb begin
    st_wr    = calc_wr;
    st_wr.we = calc_wr.we && in_vld_q && adv;
  end

  acr_level_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_level_o (rd_level),
    .wr_i       (st_wr)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      res_q <= calc_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q};

  // Assertions
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(item_q)))
    else $error("stalled item lost or changed");

  a_early_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.error_code == ERR_BAD_DEVICE ||
                   res_q.error_code == ERR_STATUS ||
                   res_q.error_code == ERR_NOT_READY))
    |-> (res_q.resistance == '0 && res_q.channel == '0 && res_q.level_after == '0))
    else $error("early error with nonzero fields");

  a_change_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.level_changed)
    |-> (res_q.error_code == ERR_OK || res_q.error_code == ERR_BELOW_RANGE))
    else $error("level change reported on an error path");

endmodule

// ===== src/acr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// acr_cfg_regs
// Coefficient and status mask registers, written through a plain write port.
// ----------------------------------------------------------------------------
module acr_cfg_regs import acr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Register writes; coefficient index i holds level i+1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff    <= '0;
      cfg_q.err_mask <= MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ERROR_MASK: cfg_q.err_mask <= cfg_wdata_i[MASK_W-1:0];
        default:        cfg_q.coeff[cfg_idx_i + 3'd1] <= cfg_wdata_i[COEFF_W-1:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/acr_level_store.sv =====
// ----------------------------------------------------------------------------
// acr_level_store
// Per device and channel excitation level, one flop entry each.
// ----------------------------------------------------------------------------
module acr_level_store import acr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [LVL_W-1:0] rd_level_o,
  input  lvl_wr_t          wr_i
);

  logic [STORE_SIZE-1:0][LVL_W-1:0] lvl_q;

  // Level update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= {STORE_SIZE{LVL_RESET}};
    end else if (wr_i.we) begin
      lvl_q[wr_i.idx] <= wr_i.level;
    end
  end

  // Read; indexes past the store only occur for rejected items
  assign rd_level_o = ({1'b0, rd_idx_i} < (IDX_W + 1)'(STORE_SIZE)) ? lvl_q[rd_idx_i]
                                                                   : LVL_RESET;

endmodule

// ===== src/acr_range_calc.sv =====
// ----------------------------------------------------------------------------
// acr_range_calc
// Checks one converter word, scales the code to ohms and picks the next level.
// ----------------------------------------------------------------------------
module acr_range_calc import acr_pkg::*; (
  input  item_t            item_i,
  input  cfg_t             cfg_i,
  output logic [IDX_W-1:0] rd_idx_o,
  input  logic [LVL_W-1:0] rd_level_i,
  output result_t          result_o,
  output lvl_wr_t          wr_o
);

  logic [CODE_W-1:0]  code;
  logic [7:0]         status;
  logic [CH_W-1:0]    ch;
  logic               dev_ok;
  logic [5:0]         idx_wide;
  logic [COEFF_W-1:0] coeff_sel;
  logic [PROD_W-1:0]  product;
  logic [RES_W-1:0]   res;
  logic [LVL_W-1:0]   nlvl;

  // Field split and store address
  always_comb begin
    code     = item_i.status_data[WORD_W-1:8];
    status   = item_i.status_data[7:0];
    ch       = status[CH_W-1:0];
    dev_ok   = (item_i.device != '0) &&
               ({1'b0, item_i.device} <= 3'(NUM_DEVICES));
    idx_wide = (6'(item_i.device) - 6'd1) * 6'(NUM_CHANNELS) + 6'(ch);
    rd_idx_o = idx_wide[IDX_W-1:0];
  end

  // Scaling: Q16 coefficient times code; the 56-bit product drops 16 bits to 40
  always_comb begin
    coeff_sel = (rd_level_i == LVL_ZERO) ? '0 : cfg_i.coeff[rd_level_i];
    product   = PROD_W'(code) * PROD_W'(coeff_sel);
    res       = product[PROD_W-1:16];
  end

  // Check chain and autorange decision
  always_comb begin
    result_o = '0;
    result_o.error_code = ERR_OK;
    wr_o     = '0;
    wr_o.idx = rd_idx_o;
    nlvl     = rd_level_i;
    if (!dev_ok) begin
      result_o.error_code = ERR_BAD_DEVICE;
    end else if ((status[MASK_W-1:0] & cfg_i.err_mask) != '0) begin
      result_o.error_code = ERR_STATUS;
    end else if (status[7]) begin
      result_o.error_code = ERR_NOT_READY;
    end else if (5'(ch) >= 5'(NUM_CHANNELS)) begin
      result_o.error_code = ERR_BAD_CHANNEL;
      result_o.channel    = ch;
    end else if (rd_level_i == LVL_ZERO) begin
      result_o.error_code = ERR_BELOW_RANGE;
      result_o.channel    = ch;
    end else if (coeff_sel == '0) begin
      result_o.error_code   = ERR_BAD_CURRENT;
      result_o.channel      = ch;
      result_o.level_before = rd_level_i;
      result_o.level_after  = rd_level_i;
    end else if (rd_level_i == LVL_ONE && code >= CODE_L1_OVER) begin
      // lowest current over range: report, keep the level
      result_o.error_code   = ERR_ABOVE_RANGE;
      result_o.channel      = ch;
      result_o.resistance   = res;
      result_o.level_before = rd_level_i;
      result_o.level_after  = rd_level_i;
    end else begin
      if (rd_level_i == LVL_ONE) begin
        if (code <= CODE_L1_RETURN) nlvl = LVL_RESET;
      end else if (code >= CODE_HIGH) begin
        nlvl = step_down(rd_level_i);
      end else if (code <= CODE_LOW) begin
        nlvl = step_up(rd_level_i);
      end
      result_o.error_code    = (nlvl == LVL_ZERO) ? ERR_BELOW_RANGE : ERR_OK;
      result_o.channel       = ch;
      result_o.resistance    = res;
      result_o.level_before  = rd_level_i;
      result_o.level_after   = nlvl;
      result_o.level_changed = (nlvl != rd_level_i);
      wr_o.we                = 1'b1;
      wr_o.level             = nlvl;
    end
  end

endmodule

// ===== tb/sv/acr_checker.sv =====
// ----------------------------------------------------------------------------
// acr_checker
// Watches the converter-word and result streams of the autorange resistance
// core. It mirrors the register writes, predicts every reading from its own
// copy of the level store and compares each result beat field by field.
// ----------------------------------------------------------------------------
module acr_checker import acr_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // fields: device[1:0], status_data[33:2], zero pad[39:34]
  input  logic [IN_TDATA_W-1:0]            s_axis_tdata,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // fields: error_code[2:0], channel[6:3], resistance[46:7],
  // level_before[49:47], level_after[52:50], level_changed[53], zero pad[55:54]
  input  logic [OUT_TDATA_W-1:0]           m_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]            cfg_wdata_i,
  output int                               mismatch_count,
  output int                               pending_beats,
  output logic [STORE_SIZE-1:0][LVL_W-1:0] level_view
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESULT_W = $bits(result_t);

  // Autorange steps, indexed by the current level
  localparam logic [7:0][LVL_W-1:0] LEVEL_DOWN =
    {3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0};
  localparam logic [7:0][LVL_W-1:0] LEVEL_UP =
    {3'd0, 3'd7, 3'd7, 3'd5, 3'd4, 3'd3, 3'd0, 3'd0};

  logic [COEFF_W-1:0] coeff_m [1:7];
  logic [MASK_W-1:0]  mask_m;
  logic [LVL_W-1:0]   level_m [STORE_SIZE];
  result_t            expected_readings [$];

  // Expected reading for one converter word; updates the level store
  function automatic result_t predict_reading(input item_t beat);
    result_t          r;
    logic [7:0]       st;
    logic [CODE_W-1:0] code;
    logic [CH_W-1:0]  ch;
    int               slot;
    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] nlvl;
    logic [PROD_W-1:0] prod;
    r = '0;
    r.error_code = ERR_OK;
    st = beat.status_data[7:0];
    code = beat.status_data[WORD_W-1:8];
    ch = st[3:0];
    if (beat.device < 1 || beat.device > NUM_DEVICES) begin
      r.error_code = ERR_BAD_DEVICE;
    end else if ((st[6:0] & mask_m) != '0) begin
      r.error_code = ERR_STATUS;
    end else if (st[7]) begin
      r.error_code = ERR_NOT_READY;
    end else if (ch >= NUM_CHANNELS) begin
      r.error_code = ERR_BAD_CHANNEL;
      r.channel = ch;
    end else begin
      r.channel = ch;
      slot = (int'(beat.device) - 1) * NUM_CHANNELS + int'(ch);
      lvl = level_m[slot];
      if (lvl == LVL_ZERO) begin
        r.error_code = ERR_BELOW_RANGE;
      end else if (coeff_m[lvl] == '0) begin
        // no usable current: report the level, keep it
        r.error_code = ERR_BAD_CURRENT;
        r.level_before = lvl;
        r.level_after = lvl;
      end else begin
        prod = PROD_W'(code) * PROD_W'(coeff_m[lvl]);
        r.resistance = prod[PROD_W-1:16];
        r.level_before = lvl;
        nlvl = lvl;
        if (lvl == LVL_ONE) begin
          // 100 nA level: own over-range limit, return to level two on low code
          if (code >= CODE_L1_OVER) r.error_code = ERR_ABOVE_RANGE;
          else if (code <= CODE_L1_RETURN) nlvl = LVL_RESET;
        end else if (code >= CODE_HIGH) begin
          nlvl = LEVEL_DOWN[lvl];
        end else if (code <= CODE_LOW) begin
          nlvl = LEVEL_UP[lvl];
        end
        level_m[slot] = nlvl;
        r.level_after = nlvl;
        r.level_changed = (nlvl != lvl);
        if (nlvl == LVL_ZERO) r.error_code = ERR_BELOW_RANGE;
      end
    end
    return r;
  endfunction

  // Register mirror, prediction on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int k = 1; k <= 7; k++) coeff_m[k] = '0;
      mask_m = MASK_RESET;
      for (int k = 0; k < STORE_SIZE; k++) level_m[k] = LVL_RESET;
      expected_readings.delete();
      mismatch_count = 0;
      pending_beats = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ERROR_MASK) mask_m = cfg_wdata_i[MASK_W-1:0];
        else coeff_m[int'(cfg_idx_i) + 1] = cfg_wdata_i[COEFF_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RESULT_W-1:0]);
        if (expected_readings.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            mismatch_count++;
          end
          if (got.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, got.channel);
            mismatch_count++;
          end
          if (got.resistance !== want.resistance) begin
            $error("resistance: expected %h, got %h", want.resistance, got.resistance);
            mismatch_count++;
          end
          if (got.level_before !== want.level_before) begin
            $error("level_before: expected %0d, got %0d", want.level_before,
                   got.level_before);
            mismatch_count++;
          end
          if (got.level_after !== want.level_after) begin
            $error("level_after: expected %0d, got %0d", want.level_after,
                   got.level_after);
            mismatch_count++;
          end
          if (got.level_changed !== want.level_changed) begin
            $error("level_changed: expected %0d, got %0d", want.level_changed,
                   got.level_changed);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(predict_reading(item_t'(s_axis_tdata[$bits(item_t)-1:0])));
      pending_beats = expected_readings.size();
    end
    // level store as seen after this edge, for the stimulus side
    for (int k = 0; k < STORE_SIZE; k++) level_view[k] <= level_m[k];
  end

endmodule

// ===== tb/sv/tb_adc_autorange_resistance_core.sv =====
// ----------------------------------------------------------------------------
// tb_adc_autorange_resistance_core
// Drives converter words and register settings into the autorange resistance
// core with random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_adc_autorange_resistance_core import acr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BEATS = 170;
  // channel deliberately run down to level zero in the directed part
  localparam int DEAD_SLOT   = (NUM_DEVICES - 1) * NUM_CHANNELS + 3;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = REG_COEFF_ONE;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;

  int                               mismatch_count;
  int                               pending_beats;
  logic [STORE_SIZE-1:0][LVL_W-1:0] level_view;

  logic [COEFF_W-1:0] coeff_set [1:7];
  logic [MASK_W-1:0]  mask_set;
  int                 rx_hold_cycles = 0;
  bit                 calm = 1'b0;
  int                 last_slot = -1;

  adc_autorange_resistance_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  acr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_count (mismatch_count),
    .pending_beats  (pending_beats),
    .level_view     (level_view)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stalls per beat, plus an occasional long hold-off
  initial begin
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // One converter word; tvalid stays high into the next beat when no gap
  task automatic send_beat(input logic [DEV_W-1:0] dev, input logic [WORD_W-1:0] word);
    int    gap;
    item_t beat;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat.device = dev;
    beat.status_data = word;
    s_axis_tdata <= IN_TDATA_W'(beat);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats != 0) @(posedge clk_i);
  endtask

  // Write all eight registers from coeff_set and mask_set while idle
  task automatic load_config();
    drain();
    repeat (4) @(posedge clk_i);
    for (int r = 0; r < 8; r++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(r);
      if (cfg_reg_e'(r) == REG_ERROR_MASK) cfg_wdata_i <= CFG_DATA_W'(mask_set);
      else cfg_wdata_i <= coeff_set[r + 1];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    last_slot = -1;
  endtask

  // Code draw; low codes only where they cannot push level seven to zero
  function automatic logic [CODE_W-1:0] pick_code(input bit low_ok);
    logic [CODE_W-1:0] edges [10];
    int                pick;
    logic [CODE_W-1:0] c;
    edges = '{CODE_HIGH - 24'd1, CODE_HIGH, CODE_L1_OVER - 24'd1, CODE_L1_OVER,
              24'hFFFFFF, CODE_LOW + 24'd1, CODE_LOW, CODE_L1_RETURN,
              CODE_L1_RETURN + 24'd1, 24'h000000};
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: c = CODE_W'($urandom_range(CODE_HIGH, 24'hFFFFFF));
      3, 4:    c = low_ok ? CODE_W'($urandom_range(0, CODE_LOW))
                          : CODE_W'($urandom_range(CODE_LOW + 1, CODE_HIGH - 1));
      5, 6:    c = CODE_W'($urandom_range(CODE_LOW + 1, CODE_HIGH - 1));
      7:       c = CODE_W'($urandom_range(CODE_L1_OVER, 24'hFFFFFF));
      8:       c = low_ok ? CODE_W'($urandom_range(0, CODE_L1_RETURN))
                          : CODE_W'($urandom_range(CODE_L1_OVER, 24'hFFFFFF));
      default: c = edges[$urandom_range(0, low_ok ? 9 : 5)];
    endcase
    return c;
  endfunction

  // Mostly well-formed words on legal channels, the rest guaranteed errors
  task automatic random_beat();
    int                kind;
    logic [DEV_W-1:0]  dev;
    logic [1:0]        ch_pick;
    logic [6:0]        st7;
    logic [CODE_W-1:0] code;
    int                slot;
    bit                low_ok;
    kind = $urandom_range(0, 99);
    code = CODE_W'($urandom);
    if (kind < 85) begin
      dev = DEV_W'($urandom_range(1, NUM_DEVICES));
      ch_pick = 2'($urandom_range(0, NUM_CHANNELS - 1));
      st7 = {3'($urandom), 2'b00, ch_pick} & ~mask_set;
      slot = (int'(dev) - 1) * NUM_CHANNELS + int'(st7[3:0]);
      low_ok = (slot == DEAD_SLOT) || (slot != last_slot && level_view[slot] != 3'd7);
      last_slot = slot;
      send_beat(dev, {pick_code(low_ok), 1'b0, st7});
    end else begin
      case (kind % 4)
        0: send_beat($urandom_range(0, 1) ? 2'd0 : 2'd3, $urandom);
        1: send_beat(DEV_W'($urandom), {code, 8'($urandom) | 8'h80});
        2: begin
          st7 = 7'($urandom);
          if ((st7 & mask_set) == '0) st7 = st7 | mask_set;
          send_beat(DEV_W'($urandom_range(1, NUM_DEVICES)),
                    {code, (mask_set == '0) ? 1'b1 : 1'($urandom), st7});
        end
        default: send_beat(DEV_W'($urandom_range(1, NUM_DEVICES)),
                           {code, 1'b0, 3'($urandom),
                            4'($urandom_range(NUM_CHANNELS, 15))});
      endcase
    end
  endtask

  // Stimulus and verdict
  initial begin
    int p;
    int i;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero coefficients and the default error mask
    send_beat(2'd1, {24'h800000, 8'h00});
    send_beat(2'd2, {24'h123456, 8'h40});

    for (int k = 1; k <= 6; k++) coeff_set[k] = $urandom | 32'd1;
    coeff_set[7] = 32'hFFFF_FFFF;
    mask_set = 7'h40;
    load_config();

    // field errors
    send_beat(2'd0, $urandom);
    send_beat(2'd3, $urandom);
    send_beat(2'd1, {24'h400000, 8'h40});
    send_beat(2'd2, {24'h400000, 8'h80});
    send_beat(2'd1, {24'h400000, 8'h04});
    send_beat(2'd2, {24'hFFFFFF, 8'h0F});
    // level one entry, over-range limit and return to level two
    send_beat(2'd1, {24'hFFFFFF, 8'h00});
    send_beat(2'd1, {CODE_L1_OVER, 8'h00});
    send_beat(2'd1, {CODE_L1_OVER - 24'd1, 8'h00});
    send_beat(2'd1, {CODE_L1_RETURN + 24'd1, 8'h00});
    send_beat(2'd1, {CODE_L1_RETURN, 8'h00});
    // thresholds that keep the level
    send_beat(2'd1, {CODE_HIGH - 24'd1, 8'h01});
    send_beat(2'd1, {CODE_LOW + 24'd1, 8'h01});
    // climb to seven, step down from seven at full-scale product
    send_beat(2'd1, {CODE_LOW, 8'h02});
    send_beat(2'd1, {24'h000000, 8'h02});
    send_beat(2'd1, {24'h000001, 8'h02});
    send_beat(2'd1, {CODE_L1_RETURN, 8'h02});
    send_beat(2'd1, {24'hFFFFFF, 8'h02});
    send_beat(2'd1, {CODE_HIGH, 8'h02});
    // run one channel off the bottom, then read it at level zero
    send_beat(2'd2, {CODE_LOW, 8'h03});
    send_beat(2'd2, {24'h000000, 8'h03});
    send_beat(2'd2, {24'h100000, 8'h03});
    send_beat(2'd2, {24'h000002, 8'h03});
    send_beat(2'd2, {CODE_LOW, 8'h03});
    send_beat(2'd2, {24'h200000, 8'h03});

    // random phases, each under its own register setting
    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          for (int k = 1; k <= 7; k++) coeff_set[k] = $urandom;
          mask_set = 7'h40;
        end
        1: begin
          for (int k = 1; k <= 7; k++) coeff_set[k] = 32'hFFFF_FFFF;
          mask_set = 7'h00;
        end
        2: begin
          for (int k = 1; k <= 7; k++) coeff_set[k] = 32'd1;
          coeff_set[1] = 32'd0;
          coeff_set[4] = 32'd0;
          mask_set = 7'h7F;
        end
        3: begin
          for (int k = 1; k <= 7; k++) coeff_set[k] = $urandom;
          mask_set = 7'($urandom_range(0, 127));
        end
        default: begin
          for (int k = 1; k <= 7; k++) coeff_set[k] = $urandom_range(1, 32'h0004_0000);
          mask_set = 7'h30;
        end
      endcase
      load_config();
      if (p == 1) rx_hold_cycles = 150;
      for (i = 0; i < PHASE_BEATS; i++) begin
        calm = (p == 3 && i < 50);
        if (i == 90) drain();
        random_beat();
      end
      calm = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
